>>> rtl/core/char_ring_buffer_with_line_detect_defines.svh
// ----------------------------------------------------------------------------
// Character ring buffer assertion macros
// Shared property macros for the checker of the character ring buffer.
// ----------------------------------------------------------------------------
`ifndef CHAR_RING_BUFFER_WITH_LINE_DETECT_DEFINES_SVH
`define CHAR_RING_BUFFER_WITH_LINE_DETECT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define CRBLD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("crbld assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define CRBLD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("crbld assertion failed");

`endif

>>> rtl/core/crbld_pkg.sv
// ----------------------------------------------------------------------------
// Character ring buffer package
// Sizes, action and status codes, payload types and small helper functions.
// ----------------------------------------------------------------------------
package crbld_pkg;

   localparam int DEPTH = 64;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = PTR_W;

   localparam logic [2:0] ACT_PUT       = 3'd0;
   localparam logic [2:0] ACT_GET       = 3'd1;
   localparam logic [2:0] ACT_BACKSPACE = 3'd2;
   localparam logic [2:0] ACT_CLEAR     = 3'd3;
   localparam logic [2:0] ACT_QUERY     = 3'd4;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   localparam logic [7:0] CHAR_LF  = 8'h0A;
   localparam logic [7:0] CHAR_CR  = 8'h0D;
   localparam logic [7:0] CHAR_CAN = 8'h18;

   typedef logic [PTR_W-1:0] ptr_type;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] byte_in;
   } req_type;

   typedef struct packed {
      logic [7:0] byte_out;
      logic [1:0] status;
      logic       is_full;
      logic       is_empty;
      logic       has_line_end;
   } rsp_type;

   // What the second stage needs to finish an item once the read data is back.
   typedef struct packed {
      logic       get_ok;
      logic       bs_ok;
      logic       put_term;
      logic       clear;
      logic [1:0] status;
      logic       is_full;
      logic       is_empty;
   } stage_info_type;

   typedef struct packed {
      logic       wr_en;
      ptr_type    wr_addr;
      logic [7:0] wr_data;
      logic       rd_en;
      ptr_type    rd_addr;
   } mem_req_type;

   function automatic logic is_terminator(input logic [7:0] c);
      return (c == CHAR_LF) || (c == CHAR_CR) || (c == CHAR_CAN);
   endfunction

   function automatic ptr_type ptr_inc(input ptr_type p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic ptr_type ptr_dec(input ptr_type p);
      return (p == '0) ? PTR_W'(DEPTH - 1) : p - 1'b1;
   endfunction

endpackage

>>> rtl/core/char_ring_buffer_with_line_detect.sv
// ----------------------------------------------------------------------------
// Character ring buffer with line-end detection
// Byte FIFO with put, get, backspace, clear and query actions, reporting
// fill state and whether a line terminator is held.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake             Payload
//   req_      in         req_valid/req_ready   req_type (action, byte_in)
//   rsp_      out        rsp_valid/rsp_ready   rsp_type (byte_out, status, flags)
//
// One transfer is taken every clock cycle while req_ready is high; each gives
// exactly one result, read through the one registered read port of the store.
// Reset clears the pointers, the terminator count and both stage valids; the
// character store is not cleared and needs no pass after reset.
// A stalled result holds in the output register while one more item waits in
// the middle stage; the input stalls only when both are occupied.
// ----------------------------------------------------------------------------
module char_ring_buffer_with_line_detect
   import crbld_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   stage_info_type stage_info;
   mem_req_type    mem_req;
   logic           stage_valid;
   logic           stage_advance;
   logic [7:0]     rd_data;

   crbld_ptr_ctrl u_ptr_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_payload   (req_payload),
      .stage_advance (stage_advance),
      .stage_valid   (stage_valid),
      .stage_info    (stage_info),
      .mem_req       (mem_req)
   );

   crbld_char_mem u_char_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   crbld_line_track u_line_track (
      .clock         (clock),
      .reset         (reset),
      .stage_valid   (stage_valid),
      .stage_info    (stage_info),
      .rd_data       (rd_data),
      .stage_advance (stage_advance),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_payload   (rsp_payload)
   );

endmodule

>>> rtl/core/crbld_char_mem.sv
// ----------------------------------------------------------------------------
// Character store
// Single write, single read memory with a registered read port.
// ----------------------------------------------------------------------------
module crbld_char_mem
   import crbld_pkg::*;
(
   input  logic        clock,
   input  mem_req_type mem_req,
   output logic [7:0]  rd_data
);

   logic [7:0] store_ff [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         store_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= store_ff[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/crbld_ptr_ctrl.sv
// ----------------------------------------------------------------------------
// Pointer control
// Takes in each transfer, decides the action against the pointers, drives the
// character store and hands the outcome to the line tracking stage.
// ----------------------------------------------------------------------------
module crbld_ptr_ctrl
   import crbld_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  req_type        req_payload,
   input  logic           stage_advance,
   output logic           stage_valid,
   output stage_info_type stage_info,
   output mem_req_type    mem_req
);

   ptr_type        rp_ff, rp_in;
   ptr_type        wp_ff, wp_in;
   logic           stage_valid_ff, stage_valid_in;
   stage_info_type stage_info_ff, stage_info_in;
   logic           accept;
   logic           empty_now;
   logic           full_now;
   ptr_type        wp_prev;

   assign req_ready = !stage_valid_ff || stage_advance;
   assign accept    = req_valid && req_ready;
   assign empty_now = (rp_ff == wp_ff);
   assign full_now  = (ptr_inc(wp_ff) == rp_ff);
   assign wp_prev   = ptr_dec(wp_ff);

   always_comb begin
      rp_in         = rp_ff;
      wp_in         = wp_ff;
      stage_info_in = '0;
      mem_req       = '0;
      mem_req.wr_addr = wp_ff;
      mem_req.wr_data = req_payload.byte_in;
      // A get reads the oldest slot; anything else reads the newest one.
      mem_req.rd_addr = (req_payload.action == ACT_GET) ? rp_ff : wp_prev;
      mem_req.rd_en   = accept;
      stage_info_in.status = ST_OK;

      case (req_payload.action)
         ACT_PUT: begin
            if (full_now) begin
               stage_info_in.status = ST_FULL;
            end else begin
               mem_req.wr_en          = accept;
               stage_info_in.put_term = is_terminator(req_payload.byte_in);
               wp_in                  = ptr_inc(wp_ff);
            end
         end
         ACT_GET: begin
            if (empty_now) begin
               stage_info_in.status = ST_EMPTY;
            end else begin
               stage_info_in.get_ok = 1'b1;
               rp_in                = ptr_inc(rp_ff);
            end
         end
         ACT_BACKSPACE: begin
            if (empty_now) begin
               stage_info_in.status = ST_EMPTY;
            end else begin
               stage_info_in.bs_ok = 1'b1;
               wp_in               = wp_prev;
            end
         end
         ACT_CLEAR: begin
            stage_info_in.clear = 1'b1;
            rp_in               = '0;
            wp_in               = '0;
         end
         default: begin
         end
      endcase

      stage_info_in.is_full  = (ptr_inc(wp_in) == rp_in);
      stage_info_in.is_empty = (rp_in == wp_in);

      if (accept) begin
         stage_valid_in = 1'b1;
      end else if (stage_advance) begin
         stage_valid_in = 1'b0;
      end else begin
         stage_valid_in = stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rp_ff          <= '0;
         wp_ff          <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         if (accept) begin
            rp_ff <= rp_in;
            wp_ff <= wp_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_info_ff <= stage_info_in;
      end
   end

   assign stage_valid = stage_valid_ff;
   assign stage_info  = stage_info_ff;

endmodule

>>> rtl/core/crbld_line_track.sv
// ----------------------------------------------------------------------------
// Line tracking and result register
// Keeps the running terminator count and builds each result transfer.
// ----------------------------------------------------------------------------
module crbld_line_track
   import crbld_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           stage_valid,
   input  stage_info_type stage_info,
   input  logic [7:0]     rd_data,
   output logic           stage_advance,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output rsp_type        rsp_payload
);

   logic [CNT_W-1:0] term_count_ff, term_count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_payload_ff, rsp_payload_in;
   logic             load;

   assign stage_advance = !rsp_valid_ff || rsp_ready;
   assign load          = stage_valid && stage_advance;

   always_comb begin
      term_count_in = term_count_ff;
      if (stage_info.clear) begin
         term_count_in = '0;
      end else if (stage_info.put_term) begin
         term_count_in = term_count_ff + 1'b1;
      end else if ((stage_info.get_ok || stage_info.bs_ok) && is_terminator(rd_data)
                   && (term_count_ff != '0)) begin
         // The character leaving the buffer was a terminator.
         term_count_in = term_count_ff - 1'b1;
      end

      rsp_payload_in.byte_out     = stage_info.get_ok ? rd_data : 8'h00;
      rsp_payload_in.status       = stage_info.status;
      rsp_payload_in.is_full      = stage_info.is_full;
      rsp_payload_in.is_empty     = stage_info.is_empty;
      rsp_payload_in.has_line_end = (term_count_in != '0);

      rsp_valid_in = stage_advance ? stage_valid : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         term_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (load) begin
            term_count_ff <= term_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

>>> rtl/core/crbld_checker.sv
// ----------------------------------------------------------------------------
// Character ring buffer checker
// Port-level properties of the ring buffer, attached by bind.
// ----------------------------------------------------------------------------
`include "char_ring_buffer_with_line_detect_defines.svh"

module crbld_checker
   import crbld_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_payload,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);

   logic rsp_xfer;

   assign rsp_xfer = rsp_valid && rsp_ready;

   // An offered input transfer stays offered and unchanged until it is taken.
   `CRBLD_ASSERT_NEXT(a_req_hold, clock, reset, req_valid && !req_ready, req_valid && $stable(req_payload))

   // A result waiting to be taken must not change.
   `CRBLD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

   // A refused put is only ever reported against a full buffer.
   `CRBLD_ASSERT_NOW(a_full_status, clock, reset, rsp_xfer && (rsp_payload.status == ST_FULL), rsp_payload.is_full)

   // A refused get or backspace leaves the buffer empty and returns no byte.
   `CRBLD_ASSERT_NOW(a_empty_status, clock, reset, rsp_xfer && (rsp_payload.status == ST_EMPTY), rsp_payload.is_empty && (rsp_payload.byte_out == 8'h00))

   // Full and empty are never reported together.
   `CRBLD_ASSERT_NOW(a_full_empty, clock, reset, rsp_valid, !(rsp_payload.is_full && rsp_payload.is_empty))

endmodule

bind char_ring_buffer_with_line_detect crbld_checker u_crbld_checker (.*);

>>> dv/crbld_check_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Character ring buffer result tracker
// Keeps a private copy of the buffer contents, pointers and terminator count,
// works out the result owed for every accepted transfer and compares each
// returned result against the oldest one still owed.
// ----------------------------------------------------------------------------
package crbld_check_pkg;

   import crbld_pkg::*;

   // Highest value the action field can carry; codes above the query act as it.
   localparam logic [2:0] ACT_CODE_MAX = 3'd7;

   localparam int REPORT_LIMIT = 10;

   class char_ring_tracker;

      logic [7:0]  char_mem [DEPTH];
      int          rd_ptr;
      int          wr_ptr;
      int          line_ends;
      rsp_type     owed_results [$];
      int unsigned failures;

      function new();
         rd_ptr    = 0;
         wr_ptr    = 0;
         line_ends = 0;
         failures  = 0;
      endfunction

      function bit is_line_char(logic [7:0] c);
         return (c == CHAR_LF) || (c == CHAR_CR) || (c == CHAR_CAN);
      endfunction

      function void report_fault(string why);
         failures++;
         if (failures <= REPORT_LIMIT) begin
            $display("[%0t] mismatch: %s", $time, why);
         end
      endfunction

      // Applies one accepted action to the private copy and queues its result.
      function void apply_action(req_type item);
         rsp_type want;
         bit      was_empty;
         int      next_wr;
         int      prev_wr;
         want        = '0;
         want.status = ST_OK;
         was_empty   = (rd_ptr == wr_ptr);
         case (item.action)
            ACT_PUT: begin
               next_wr = (wr_ptr + 1) % DEPTH;
               if (next_wr == rd_ptr) begin
                  want.status = ST_FULL;
               end else begin
                  char_mem[wr_ptr] = item.byte_in;
                  if (is_line_char(item.byte_in)) line_ends++;
                  wr_ptr = next_wr;
               end
            end
            ACT_GET: begin
               if (was_empty) begin
                  want.status = ST_EMPTY;
               end else begin
                  want.byte_out = char_mem[rd_ptr];
                  if (is_line_char(want.byte_out) && line_ends > 0) line_ends--;
                  rd_ptr = (rd_ptr + 1) % DEPTH;
               end
            end
            ACT_BACKSPACE: begin
               if (was_empty) begin
                  want.status = ST_EMPTY;
               end else begin
                  prev_wr = (wr_ptr == 0) ? DEPTH - 1 : wr_ptr - 1;
                  if (is_line_char(char_mem[prev_wr]) && line_ends > 0) line_ends--;
                  wr_ptr = prev_wr;
               end
            end
            ACT_CLEAR: begin
               // The stored characters stay; only the bookkeeping is reset.
               rd_ptr    = 0;
               wr_ptr    = 0;
               line_ends = 0;
            end
            default: begin
            end
         endcase
         want.is_full      = (((wr_ptr + 1) % DEPTH) == rd_ptr);
         want.is_empty     = (rd_ptr == wr_ptr);
         want.has_line_end = (line_ends != 0);
         owed_results.push_back(want);
      endfunction

      function void compare_result(rsp_type got);
         rsp_type want;
         string   diffs;
         if (owed_results.size() == 0) begin
            report_fault($sformatf("result %h arrived with none owed", got));
            return;
         end
         want  = owed_results.pop_front();
         diffs = "";
         if (got.byte_out !== want.byte_out)
            diffs = {diffs, $sformatf(" byte_out exp %h got %h", want.byte_out, got.byte_out)};
         if (got.status !== want.status)
            diffs = {diffs, $sformatf(" status exp %0d got %0d", want.status, got.status)};
         if (got.is_full !== want.is_full)
            diffs = {diffs, $sformatf(" is_full exp %b got %b", want.is_full, got.is_full)};
         if (got.is_empty !== want.is_empty)
            diffs = {diffs, $sformatf(" is_empty exp %b got %b", want.is_empty, got.is_empty)};
         if (got.has_line_end !== want.has_line_end)
            diffs = {diffs, $sformatf(" has_line_end exp %b got %b",
                                      want.has_line_end, got.has_line_end)};
         if (diffs != "") report_fault(diffs);
      endfunction

      function int unsigned owed();
         return owed_results.size();
      endfunction

      function void close_out();
         if (owed_results.size() != 0) begin
            report_fault($sformatf("%0d results never arrived", owed_results.size()));
         end
      endfunction

   endclass

endpackage

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Character ring buffer testbench
// Drives put, get, backspace, clear and query transfers through the valid and
// ready channels with bursty input and a patterned, sometimes stalled output,
// and checks every result against an independent copy of the buffer.
// ----------------------------------------------------------------------------
module tb_top;

   import crbld_pkg::*;
   import crbld_check_pkg::*;

   localparam int RANDOM_ITEMS    = 1700;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_LIMIT     = 20000;
   localparam int SETTLE_CYCLES   = 8;

   typedef enum {MIX_FILL, MIX_DRAIN, MIX_BALANCED, MIX_TRIM} traffic_mix_type;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;

   char_ring_tracker tracker = new();
   int unsigned      burst_left = 0;

   char_ring_buffer_with_line_detect dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Both handshakes are observed here so that a transfer is always noted
   // before any result of the same edge is compared.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) tracker.apply_action(req_payload);
         if (rsp_valid && rsp_ready) tracker.compare_result(rsp_payload);
      end
   end

   function automatic req_type random_req(input traffic_mix_type mix);
      req_type     item;
      int unsigned roll;
      int unsigned put_lim, get_lim, bs_lim, clr_lim;
      case (mix)
         MIX_FILL:  begin put_lim = 72; get_lim = 82; bs_lim = 90; clr_lim = 91; end
         MIX_DRAIN: begin put_lim = 20; get_lim = 75; bs_lim = 88; clr_lim = 90; end
         MIX_TRIM:  begin put_lim = 50; get_lim = 58; bs_lim = 90; clr_lim = 91; end
         default:   begin put_lim = 45; get_lim = 78; bs_lim = 90; clr_lim = 93; end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < put_lim)      item.action = ACT_PUT;
      else if (roll < get_lim) item.action = ACT_GET;
      else if (roll < bs_lim)  item.action = ACT_BACKSPACE;
      else if (roll < clr_lim) item.action = ACT_CLEAR;
      else                     item.action = 3'($urandom_range(ACT_QUERY, ACT_CODE_MAX));
      // At least a quarter of the characters are line terminators.
      case ($urandom_range(0, 11))
         0:       item.byte_in = CHAR_LF;
         1:       item.byte_in = CHAR_CR;
         2:       item.byte_in = CHAR_CAN;
         default: item.byte_in = 8'($urandom_range(0, 255));
      endcase
      return item;
   endfunction

   // Offers one item, opening a new burst after a random gap when the
   // current one is used up, and returns at the edge of its transfer.
   task automatic send_item(input req_type item);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(1, 40);
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   initial begin : receiver
      logic [7:0]  pattern;
      int unsigned span;
      int unsigned segment;
      segment = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         segment++;
         if (segment == 4) begin
            // Long hold-off while input keeps coming, so the pipeline fills.
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            case ($urandom_range(0, 3))
               0:       pattern = 8'hFF;
               1:       pattern = 8'hAA;
               default: pattern = 8'($urandom_range(0, 255)) | 8'h01;
            endcase
            span = $urandom_range(20, 200);
            for (int unsigned i = 0; i < span; i++) begin
               rsp_ready <= pattern[i % 8];
               @(posedge clock);
            end
         end
      end
   end

   initial begin : stimulus
      req_type         directed [$];
      traffic_mix_type mix;
      int unsigned     mix_left;
      int unsigned     waited;
      directed = '{
         '{ACT_QUERY, 8'h00}, '{ACT_GET, 8'hFF}, '{ACT_BACKSPACE, 8'h5A},
         '{ACT_PUT, 8'h00}, '{ACT_PUT, 8'hFF}, '{ACT_PUT, CHAR_LF},
         '{ACT_PUT, CHAR_CR}, '{ACT_PUT, CHAR_CAN},
         '{3'(ACT_QUERY + 1), 8'h11}, '{3'(ACT_QUERY + 2), 8'h22}, '{ACT_CODE_MAX, 8'h33},
         '{ACT_GET, 8'h00}, '{ACT_BACKSPACE, 8'h00}, '{ACT_GET, 8'h00},
         '{ACT_GET, 8'h00}, '{ACT_BACKSPACE, 8'h00}, '{ACT_GET, 8'h00},
         '{ACT_PUT, 8'h55}, '{ACT_PUT, 8'hAA}, '{ACT_CLEAR, 8'h00},
         '{ACT_QUERY, 8'h00}, '{ACT_CLEAR, 8'hC3}, '{ACT_PUT, CHAR_LF},
         '{ACT_BACKSPACE, 8'h00}
      };
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) send_item(directed[i]);

      mix      = MIX_FILL;
      mix_left = $urandom_range(80, 160);
      for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
         if (mix_left == 0) begin
            mix      = traffic_mix_type'($urandom_range(0, 3));
            mix_left = $urandom_range(80, 160);
         end
         mix_left--;
         send_item(random_req(mix));
      end
      req_valid <= 1'b0;

      waited = 0;
      while (tracker.owed() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      tracker.close_out();
      if (tracker.failures == 0) begin
         $display("** char_ring_buffer_with_line_detect: PASSED **");
      end else begin
         $display("** char_ring_buffer_with_line_detect: FAILED **");
      end
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("[%0t] run did not complete in time", $time);
      $display("** char_ring_buffer_with_line_detect: FAILED **");
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/crbld_pkg.sv
rtl/core/crbld_char_mem.sv
rtl/core/crbld_ptr_ctrl.sv
rtl/core/crbld_line_track.sv
rtl/core/char_ring_buffer_with_line_detect.sv
rtl/core/crbld_checker.sv
dv/crbld_check_pkg.sv
dv/tb_top.sv
